// ===== rtl/floor_amplitude_synthesis_top_assert.svh =====
// Assertion macros shared by the floor amplitude synthesis RTL.
// Each macro expects clk and rst_n in scope.
`ifndef FLOOR_AMPLITUDE_SYNTHESIS_TOP_ASSERT_SVH
`define FLOOR_AMPLITUDE_SYNTHESIS_TOP_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define FAS_ASSERT_IMPLY(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define FAS_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/fas_pkg.sv =====
// ----------------------------------------------------------------------------
// fas_pkg
// Types and constants for the floor amplitude synthesis block.
// ----------------------------------------------------------------------------
`default_nettype none

package fas_pkg;

  // Field widths
  localparam int unsigned IDX_W = 7;
  localparam int unsigned AMP_W = 8;
  localparam int unsigned X_W   = 15;
  localparam int unsigned RS_W  = 3;
  localparam int unsigned RNG_W = 9;

  // Request function codes
  localparam logic [1:0] FUNC_STORE = 2'd0;
  localparam logic [1:0] FUNC_POINT = 2'd1;
  localparam logic [1:0] FUNC_READ  = 2'd2;

  // Amplitude range per floor multiplier
  localparam logic [RNG_W-1:0] RANGE_MULT1 = 9'd256;
  localparam logic [RNG_W-1:0] RANGE_MULT2 = 9'd128;
  localparam logic [RNG_W-1:0] RANGE_MULT3 = 9'd86;
  localparam logic [RNG_W-1:0] RANGE_MULT4 = 9'd64;
  localparam logic [RS_W-1:0]  RANGE_SELECT_RESET = 3'd1;

  // Divider geometry: product dy*dx, padded to an even bit count, 2 bits a cycle
  localparam int unsigned PROD_W    = AMP_W + X_W;
  localparam int unsigned DIV_W     = PROD_W + (PROD_W % 2);
  localparam int unsigned DIV_STEPS = DIV_W / 2;
  localparam int unsigned DIV_CNT_W = $clog2(DIV_STEPS + 1);

  typedef struct packed {
    logic [1:0]       func;
    logic [IDX_W-1:0] point_index;
    logic [AMP_W-1:0] raw_value;
    logic [X_W-1:0]   x_this;
    logic [X_W-1:0]   x_low;
    logic [X_W-1:0]   x_high;
    logic [IDX_W-1:0] low_index;
    logic [IDX_W-1:0] high_index;
  } in_t;

  typedef struct packed {
    logic [IDX_W-1:0] entry_index;
    logic [AMP_W-1:0] amplitude;
    logic             unused_mark;
    logic             clamped;
  } out_t;

  // Divider status toward the sequencer
  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

`default_nettype wire

// ===== rtl/fas_div.sv =====
// ----------------------------------------------------------------------------
// fas_div
// Restoring unsigned divider, two quotient bits per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module fas_div (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          start,
  input  wire logic [fas_pkg::PROD_W-1:0]    dividend,
  input  wire logic [fas_pkg::X_W-1:0]       divisor,
  output fas_pkg::div_stat_t                 stat,
  output logic [fas_pkg::PROD_W-1:0]         quotient
);

  localparam int unsigned DW = fas_pkg::DIV_W;
  localparam int unsigned XW = fas_pkg::X_W;

  logic [DW-1:0]                  num_r;
  logic [DW-1:0]                  quo_r;
  logic [XW-1:0]                  rem_r;
  logic [XW-1:0]                  dsr_r;
  logic [fas_pkg::DIV_CNT_W-1:0]  cnt_r;
  logic                           busy_r;
  logic                           done_r;

  logic [DW-1:0] num_nxt;
  logic [DW-1:0] quo_nxt;
  logic [XW-1:0] rem_nxt;
  logic [XW:0]   trial;

  // Two compare/subtract steps per cycle
  always_comb begin
    num_nxt = num_r;
    quo_nxt = quo_r;
    rem_nxt = rem_r;
    trial   = '0;
    for (int k = 0; k < 2; k++) begin
      trial   = {rem_nxt, num_nxt[DW-1]};
      num_nxt = {num_nxt[DW-2:0], 1'b0};
      if (trial >= {1'b0, dsr_r}) begin
        rem_nxt = XW'(trial - {1'b0, dsr_r});
        quo_nxt = {quo_nxt[DW-2:0], 1'b1};
      end else begin
        rem_nxt = trial[XW-1:0];
        quo_nxt = {quo_nxt[DW-2:0], 1'b0};
      end
    end
  end

  // Iteration control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      // one-cycle pulse after the last step
      done_r <= !start && busy_r &&
                (cnt_r == fas_pkg::DIV_CNT_W'(fas_pkg::DIV_STEPS - 1));
      if (start) begin
        num_r  <= DW'(dividend);
        quo_r  <= '0;
        rem_r  <= '0;
        dsr_r  <= divisor;
        cnt_r  <= '0;
        busy_r <= 1'b1;
      end else if (busy_r) begin
        num_r <= num_nxt;
        quo_r <= quo_nxt;
        rem_r <= rem_nxt;
        cnt_r <= cnt_r + fas_pkg::DIV_CNT_W'(1);
        if (cnt_r == fas_pkg::DIV_CNT_W'(fas_pkg::DIV_STEPS - 1)) begin
          busy_r <= 1'b0;
        end
      end
    end
  end

  assign stat.busy = busy_r;
  assign stat.done = done_r;
  assign quotient  = quo_r[fas_pkg::PROD_W-1:0];

endmodule

`default_nettype wire

// ===== rtl/floor_amplitude_synthesis_top.sv =====
// ----------------------------------------------------------------------------
// floor_amplitude_synthesis_top
// Floor1 amplitude list rebuild: endpoint store, point synthesis, entry read.
// ----------------------------------------------------------------------------
// Usage:
//   Requests enter on in_valid/in_ready with an fas_pkg::in_t payload; one
//   result per request (func 0, 1 or 2) leaves on out_valid/out_ready as an
//   fas_pkg::out_t. Func 3 is taken and dropped with no result.
//   cfg_valid/cfg_ready writes range_select; cfg_ready is always high. The
//   user makes writes only with no request in flight; the block does not
//   enforce it. One request is in work at a time: a store goes straight to
//   the finish state, a read passes the entry read state, and a point
//   request reads the high neighbor, preps, multiplies, waits on the divider,
//   predicts and unwraps, writing the point; the single mark write port then
//   takes the two neighbor clears in turn unless the code is zero.
//   Amplitudes and unused marks live in two synchronous memories of POINTS
//   entries. Reset clears control only: range_select returns to 1, memories
//   are not cleared and must be written before use.
//   If the receiver stalls, the finished result waits in the output register;
//   the next request is still taken, and its result waits until the register
//   frees.
// ----------------------------------------------------------------------------
`default_nettype none

module floor_amplitude_synthesis_top #(
  parameter int unsigned POINTS = 128
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        in_valid,
  output logic                             in_ready,
  input  wire fas_pkg::in_t                in_data,
  output logic                             out_valid,
  input  wire logic                        out_ready,
  output fas_pkg::out_t                    out_data,
  input  wire logic                        cfg_valid,
  output logic                             cfg_ready,
  input  wire logic [fas_pkg::RS_W-1:0]    cfg_data
);

  localparam int unsigned AW    = $clog2(POINTS);
  localparam int unsigned IW    = fas_pkg::IDX_W;
  localparam int unsigned MW    = fas_pkg::AMP_W;
  localparam int unsigned XW    = fas_pkg::X_W;
  localparam int unsigned RW    = fas_pkg::RNG_W;
  localparam int unsigned PW    = fas_pkg::PROD_W;
  localparam int unsigned PV_W  = PW + 2;
  localparam int unsigned VW    = 12;

  typedef enum logic [3:0] {
    S_IDLE, S_RD_HI, S_PREP, S_MUL, S_DIV_GO, S_DIV,
    S_PRED, S_UNWRAP, S_CLR_LO, S_CLR_HI, S_RD_ENT, S_FINISH
  } state_t;

  state_t                   state_r;
  logic [fas_pkg::RS_W-1:0] range_select_r;

  // Latched request
  logic [IW-1:0] idx_r, lo_r, hi_r;
  logic [MW-1:0] raw_r;
  logic [XW-1:0] xt_r, xl_r, xh_r;
  logic          idx_ok_r, lo_ok_r, hi_ok_r;

  // Interpolation datapath
  logic [MW-1:0] y0_r;
  logic [MW-1:0] dy_abs_r;
  logic [XW-1:0] dx_abs_r;
  logic [XW-1:0] span_abs_r;
  logic          span_zero_r;
  logic          neg_r;
  logic [PW-1:0] prod_r;
  logic [MW-1:0] pred_r;
  logic          flag_r;

  fas_pkg::out_t res_r;
  fas_pkg::out_t out_data_r;
  logic          out_valid_r;

  // Memories
  logic [MW-1:0] amp_mem  [POINTS];
  logic          mark_mem [POINTS];
  logic [MW-1:0] amp_rd_r;
  logic          mark_rd_r;

  logic          rd_en;
  logic [AW-1:0] rd_addr;
  logic          amp_we, mark_we;
  logic [AW-1:0] wr_addr;
  logic [MW-1:0] amp_wd;
  logic          mark_wd;

  logic in_fire;
  logic in_idx_ok;
  logic can_load;

  // Range decode
  logic [RW-1:0] amp_range;
  logic [MW-1:0] range_m1;

  always_comb begin
    case (range_select_r) inside
      3'd0, 3'd1: amp_range = fas_pkg::RANGE_MULT1;
      3'd2:       amp_range = fas_pkg::RANGE_MULT2;
      3'd3:       amp_range = fas_pkg::RANGE_MULT3;
      default:    amp_range = fas_pkg::RANGE_MULT4;
    endcase
  end

  assign range_m1 = MW'(amp_range - RW'(1));

  assign in_ready  = (state_r == S_IDLE);
  assign in_fire   = in_valid && in_ready;
  assign in_idx_ok = 32'(in_data.point_index) < POINTS;
  assign cfg_ready = 1'b1;
  assign can_load  = !out_valid_r || out_ready;

  // Endpoint clamp
  logic          ep_flag;
  logic [MW-1:0] ep_amp;

  assign ep_flag = in_data.raw_value > range_m1;
  assign ep_amp  = ep_flag ? range_m1 : in_data.raw_value;

  // Deltas and their magnitudes
  logic [MW-1:0]        y1;
  logic signed [MW:0]   dy_s;
  logic signed [XW:0]   span_s;
  logic signed [XW:0]   dx_s;

  assign y1     = hi_ok_r ? amp_rd_r : '0;
  assign dy_s   = $signed({1'b0, y1}) - $signed({1'b0, y0_r});
  assign span_s = $signed({1'b0, xh_r}) - $signed({1'b0, xl_r});
  assign dx_s   = $signed({1'b0, xt_r}) - $signed({1'b0, xl_r});

  // Divider
  fas_pkg::div_stat_t div_st;
  logic               div_start;
  logic [PW-1:0]      div_q;

  assign div_start = (state_r == S_DIV_GO);

  fas_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (prod_r),
    .divisor  (span_abs_r),
    .stat     (div_st),
    .quotient (div_q)
  );

  // Prediction and clamp
  logic [PW-1:0]   off;
  logic [PV_W-1:0] pv;
  logic [MW-1:0]   pred_c;
  logic            pred_flag;

  always_comb begin
    off = span_zero_r ? '0 : div_q;
    pv  = neg_r ? (PV_W'(y0_r) - PV_W'(off)) : (PV_W'(y0_r) + PV_W'(off));
    if (pv[PV_W-1]) begin
      pred_c    = '0;
      pred_flag = 1'b1;
    end else if (pv > PV_W'(range_m1)) begin
      pred_c    = range_m1;
      pred_flag = 1'b1;
    end else begin
      pred_c    = pv[MW-1:0];
      pred_flag = 1'b0;
    end
  end

  // Unwrap the code against the room to the range limits
  logic [RW-1:0]   hroom, lroom, mroom;
  logic [RW:0]     room;
  logic [RW-1:0]   half_up;
  logic [VW-1:0]   uval;
  logic [VW-1:0]   usum;
  logic [MW-1:0]   unw_amp;
  logic            unw_flag;

  always_comb begin
    hroom   = amp_range - RW'(pred_r);
    lroom   = RW'(pred_r);
    mroom   = (hroom < lroom) ? hroom : lroom;
    room    = {mroom, 1'b0};
    half_up = (RW'(raw_r) + RW'(1)) >> 1;
    if ((RW+1)'(raw_r) >= room) begin
      if (hroom > lroom) uval = VW'(raw_r) - VW'(pred_r);
      else               uval = VW'(hroom) - VW'(1) - VW'(raw_r);
    end else if (raw_r[0]) begin
      uval = VW'(0) - VW'(half_up);
    end else begin
      uval = VW'(raw_r >> 1);
    end
    usum = uval + VW'(pred_r);
    if (usum[VW-1]) begin
      unw_amp  = '0;
      unw_flag = 1'b1;
    end else if (usum > VW'(range_m1)) begin
      unw_amp  = range_m1;
      unw_flag = 1'b1;
    end else begin
      unw_amp  = usum[MW-1:0];
      unw_flag = 1'b0;
    end
  end

  logic          code_zero;
  logic [MW-1:0] fin_amp;

  assign code_zero = (raw_r == '0);
  assign fin_amp   = code_zero ? pred_r : unw_amp;

  // Memory port selection
  always_comb begin
    rd_en   = 1'b0;
    rd_addr = AW'(lo_r);
    amp_we  = 1'b0;
    mark_we = 1'b0;
    wr_addr = AW'(idx_r);
    amp_wd  = fin_amp;
    mark_wd = 1'b0;
    case (state_r)
      S_IDLE: begin
        rd_en   = in_fire && (in_data.func == fas_pkg::FUNC_POINT ||
                              in_data.func == fas_pkg::FUNC_READ);
        rd_addr = (in_data.func == fas_pkg::FUNC_READ) ? AW'(in_data.point_index)
                                                        : AW'(in_data.low_index);
        wr_addr = AW'(in_data.point_index);
        amp_wd  = ep_amp;
        if (in_fire && in_data.func == fas_pkg::FUNC_STORE && in_idx_ok) begin
          amp_we  = 1'b1;
          mark_we = 1'b1;
        end
      end
      S_RD_HI: begin
        rd_en   = 1'b1;
        rd_addr = AW'(hi_r);
      end
      S_UNWRAP: begin
        amp_we  = idx_ok_r;
        mark_we = idx_ok_r;
        mark_wd = code_zero;
      end
      S_CLR_LO: begin
        mark_we = lo_ok_r;
        wr_addr = AW'(lo_r);
      end
      S_CLR_HI: begin
        mark_we = hi_ok_r;
        wr_addr = AW'(hi_r);
      end
      default: begin
      end
    endcase
  end

  // Amplitude and mark memories, registered read
  always_ff @(posedge clk) begin
    if (amp_we)  amp_mem[wr_addr]  <= amp_wd;
    if (mark_we) mark_mem[wr_addr] <= mark_wd;
    if (rd_en) begin
      amp_rd_r  <= amp_mem[rd_addr];
      mark_rd_r <= mark_mem[rd_addr];
    end
  end

  // Sequencer, datapath registers and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= S_IDLE;
      range_select_r <= fas_pkg::RANGE_SELECT_RESET;
      out_valid_r    <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) range_select_r <= cfg_data;
      // in S_FINISH a taken result is replaced by the next one below
      if (out_ready && state_r != S_FINISH) out_valid_r <= 1'b0;

      case (state_r)
        S_IDLE: begin
          if (in_fire) begin
            idx_r    <= in_data.point_index;
            lo_r     <= in_data.low_index;
            hi_r     <= in_data.high_index;
            raw_r    <= in_data.raw_value;
            xt_r     <= in_data.x_this;
            xl_r     <= in_data.x_low;
            xh_r     <= in_data.x_high;
            idx_ok_r <= in_idx_ok;
            lo_ok_r  <= 32'(in_data.low_index) < POINTS;
            hi_ok_r  <= 32'(in_data.high_index) < POINTS;
            case (in_data.func)
              fas_pkg::FUNC_STORE: begin
                res_r.entry_index <= in_data.point_index;
                res_r.amplitude   <= in_idx_ok ? ep_amp : '0;
                res_r.unused_mark <= 1'b0;
                res_r.clamped     <= ep_flag;
                state_r           <= S_FINISH;
              end
              fas_pkg::FUNC_POINT: state_r <= S_RD_HI;
              fas_pkg::FUNC_READ:  state_r <= S_RD_ENT;
              default:             state_r <= S_IDLE;
            endcase
          end
        end
        S_RD_HI: begin
          y0_r    <= lo_ok_r ? amp_rd_r : '0;
          state_r <= S_PREP;
        end
        S_PREP: begin
          dy_abs_r    <= dy_s[MW] ? MW'(-dy_s) : MW'(dy_s);
          dx_abs_r    <= dx_s[XW] ? XW'(-dx_s) : XW'(dx_s);
          span_abs_r  <= span_s[XW] ? XW'(-span_s) : XW'(span_s);
          span_zero_r <= (xh_r == xl_r);
          neg_r       <= dy_s[MW] ^ dx_s[XW] ^ span_s[XW];
          state_r     <= S_MUL;
        end
        S_MUL: begin
          prod_r  <= PW'(dy_abs_r) * PW'(dx_abs_r);
          state_r <= S_DIV_GO;
        end
        S_DIV_GO: begin
          state_r <= S_DIV;
        end
        S_DIV: begin
          if (div_st.done) state_r <= S_PRED;
        end
        S_PRED: begin
          pred_r  <= pred_c;
          flag_r  <= pred_flag;
          state_r <= S_UNWRAP;
        end
        S_UNWRAP: begin
          res_r.entry_index <= idx_r;
          res_r.amplitude   <= idx_ok_r ? fin_amp : '0;
          res_r.unused_mark <= idx_ok_r && code_zero;
          res_r.clamped     <= flag_r || (!code_zero && unw_flag);
          state_r           <= code_zero ? S_FINISH : S_CLR_LO;
        end
        S_CLR_LO: state_r <= S_CLR_HI;
        S_CLR_HI: state_r <= S_FINISH;
        S_RD_ENT: begin
          res_r.entry_index <= idx_r;
          res_r.amplitude   <= idx_ok_r ? amp_rd_r : '0;
          res_r.unused_mark <= idx_ok_r && mark_rd_r;
          res_r.clamped     <= 1'b0;
          state_r           <= S_FINISH;
        end
        S_FINISH: begin
          if (can_load) begin
            out_data_r  <= res_r;
            out_valid_r <= 1'b1;
            state_r     <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Assertions
`include "floor_amplitude_synthesis_top_assert.svh"

  `FAS_ASSERT_IMPLY(a_idle_write_is_store, amp_we && state_r == S_IDLE, in_fire && in_data.func == fas_pkg::FUNC_STORE, "memory write in idle without a store request")
  `FAS_ASSERT_IMPLY(a_div_start_free, div_start, !div_st.busy, "divider started while busy")
  `FAS_ASSERT_IMPLY(a_div_done_state, div_st.done, state_r == S_DIV, "divider finished outside the wait state")
  `FAS_ASSERT_NEXT(a_finish_loads, state_r == S_FINISH && can_load, out_valid_r && state_r == S_IDLE, "finished result not loaded into the output register")

endmodule

`default_nettype wire
